### hdl/ibpa_pkg.sv
package ibpa_pkg;

  // Fixed field widths
  localparam int COORD_BITS = 12;
  localparam int COLOR_W    = 8;
  localparam int CIDX_W     = $clog2(COLOR_W);
  localparam int DEPTH_W    = 4;
  localparam int STRIDE_W   = 13;
  localparam int WORD_W     = 16;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Parameter defaults
  localparam int FB_WORDS_DEF  = 65536;
  localparam int MAX_DEPTH_DEF = 8;

  // Register reset values
  localparam logic [DEPTH_W-1:0]  DEPTH_RST  = 4'd4;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd80;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Item kinds
  localparam logic KIND_PUT = 1'b0;
  localparam logic KIND_GET = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_DEPTH = 1'b0,
    REG_LINE_STRIDE = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_W-1:0]    pixel_color;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] read_color;
    logic               out_of_range;
  } out_item_t;

  // Classified job handed from front to back (word address travels beside it)
  typedef struct packed {
    logic               kind;
    logic [BIT_W-1:0]   x_lo;
    logic [COLOR_W-1:0] color;
    logic [DEPTH_W-1:0] planes;
    logic               outside;
  } job_t;

endpackage

### hdl/ibpa_front.sv
module ibpa_front #(
  parameter int FB_WORDS  = ibpa_pkg::FB_WORDS_DEF,
  parameter int MAX_DEPTH = ibpa_pkg::MAX_DEPTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  ibpa_pkg::in_item_t                      item,
  input  logic                                    cfg_we,
  input  logic [ibpa_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [ibpa_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  logic                                    clearing,
  input  logic [$clog2(ibpa_pkg::QUEUE_DEPTH+1)-1:0] q_count,
  output logic                                    busy,
  output logic                                    push,
  output logic [$clog2(FB_WORDS)-1:0]             push_base,
  output ibpa_pkg::job_t                          push_job
);

  localparam int ADDR_W = $clog2(FB_WORDS);
  localparam int CNT_W  = $clog2(ibpa_pkg::QUEUE_DEPTH + 1);
  localparam int PY_W   = ibpa_pkg::COORD_BITS + ibpa_pkg::STRIDE_W;
  localparam int PX_W   = ibpa_pkg::COORD_BITS - ibpa_pkg::BIT_W + ibpa_pkg::DEPTH_W;
  localparam int BASE_W = PY_W + 1;

  logic [ibpa_pkg::DEPTH_W-1:0]  plane_depth;
  logic [ibpa_pkg::STRIDE_W-1:0] line_stride_words;

  logic                          s1_valid;
  logic                          s1_kind;
  logic [ibpa_pkg::BIT_W-1:0]    s1_x_lo;
  logic [ibpa_pkg::COLOR_W-1:0]  s1_color;
  logic [ibpa_pkg::DEPTH_W-1:0]  s1_depth;
  logic [ibpa_pkg::DEPTH_W-1:0]  s1_planes;
  logic [PY_W-1:0]               s1_prod_y;
  logic [PX_W-1:0]               s1_prod_x;

  logic [ibpa_pkg::DEPTH_W-1:0]  eff_depth;
  logic [ibpa_pkg::DEPTH_W-1:0]  planes;
  logic [PY_W-1:0]               prod_y;
  logic [PX_W-1:0]               prod_x;
  logic [BASE_W-1:0]             base;
  logic                          outside;
  logic                          accept;

  // depth saturates at MAX_DEPTH; a get never looks past the colour width
  always_comb begin
    eff_depth = (32'(plane_depth) > MAX_DEPTH) ? ibpa_pkg::DEPTH_W'(MAX_DEPTH) : plane_depth;
    planes    = eff_depth;
    if (item.kind == ibpa_pkg::KIND_GET && 32'(eff_depth) > ibpa_pkg::COLOR_W) begin
      planes = ibpa_pkg::DEPTH_W'(ibpa_pkg::COLOR_W);
    end
  end

  assign prod_y = PY_W'(item.y) * PY_W'(line_stride_words);
  assign prod_x = PX_W'(item.x[ibpa_pkg::COORD_BITS-1:ibpa_pkg::BIT_W]) * PX_W'(eff_depth);

  assign busy = clearing ||
                ((CNT_W+1)'(q_count) + (CNT_W+1)'(s1_valid) >= (CNT_W+1)'(ibpa_pkg::QUEUE_DEPTH));
  assign accept = start && !busy;

  // second stage: sum the products, bound check
  assign base    = BASE_W'(s1_prod_y) + BASE_W'(s1_prod_x);
  assign outside = (base + BASE_W'(s1_depth)) > BASE_W'(FB_WORDS);

  assign push      = s1_valid;
  assign push_base = base[ADDR_W-1:0];
  always_comb begin
    push_job.kind    = s1_kind;
    push_job.x_lo    = s1_x_lo;
    push_job.color   = s1_color;
    push_job.planes  = s1_planes;
    push_job.outside = outside;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_depth       <= ibpa_pkg::DEPTH_RST;
      line_stride_words <= ibpa_pkg::STRIDE_RST;
      s1_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (ibpa_pkg::cfg_reg_t'(cfg_index))
          ibpa_pkg::REG_PLANE_DEPTH: plane_depth <= cfg_data[ibpa_pkg::DEPTH_W-1:0];
          ibpa_pkg::REG_LINE_STRIDE: line_stride_words <= cfg_data[ibpa_pkg::STRIDE_W-1:0];
          default: ;
        endcase
      end
      s1_valid <= accept;
    end
    if (accept) begin
      s1_kind   <= item.kind;
      s1_x_lo   <= item.x[ibpa_pkg::BIT_W-1:0];
      s1_color  <= item.pixel_color;
      s1_depth  <= eff_depth;
      s1_planes <= planes;
      s1_prod_y <= prod_y;
      s1_prod_x <= prod_x;
    end
  end

endmodule

### hdl/ibpa_queue.sv
module ibpa_queue #(
  parameter int W = 1
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  input  logic [W-1:0]                               wdata,
  input  logic                                       pop,
  output logic [W-1:0]                               rdata,
  output logic                                       not_empty,
  output logic [$clog2(ibpa_pkg::QUEUE_DEPTH+1)-1:0] count
);

  localparam int QD    = ibpa_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(QD);
  localparam int CNT_W = $clog2(QD + 1);

  logic [W-1:0]     slots [QD];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign rdata     = slots[rd_ptr];
  assign not_empty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QD - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QD - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

### hdl/ibpa_back.sv
module ibpa_back #(
  parameter int FB_WORDS = ibpa_pkg::FB_WORDS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  logic [$clog2(FB_WORDS)-1:0] q_base,
  input  ibpa_pkg::job_t              q_job,
  output logic                        pop,
  output logic                        clearing,
  output logic                        result_valid,
  output ibpa_pkg::out_item_t         result
);

  localparam int ADDR_W = $clog2(FB_WORDS);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_MODIFY
  } state_t;

  state_t                        state;
  ibpa_pkg::job_t                job;
  logic [ADDR_W-1:0]             base;
  logic [ADDR_W-1:0]             clr_addr;
  logic [ibpa_pkg::DEPTH_W-1:0]  plane;
  logic [ibpa_pkg::COLOR_W-1:0]  acc;

  logic [ibpa_pkg::WORD_W-1:0]   mem [FB_WORDS];
  logic [ibpa_pkg::WORD_W-1:0]   mem_rdata;
  logic                          mem_we;
  logic [ADDR_W-1:0]             mem_waddr;
  logic [ibpa_pkg::WORD_W-1:0]   mem_wdata;

  logic [ADDR_W-1:0]             plane_addr;
  logic [ibpa_pkg::WORD_W-1:0]   mask;
  logic [ibpa_pkg::BIT_W-1:0]    bitpos;
  logic                          put_bit;
  logic                          last_plane;
  logic [ibpa_pkg::COLOR_W-1:0]  acc_next;

  assign clearing   = (state == ST_CLEAR);
  assign pop        = (state == ST_IDLE) && q_valid;
  assign plane_addr = base + ADDR_W'(plane);
  assign bitpos     = ~job.x_lo;  // leftmost pixel in the MSB
  assign mask       = ibpa_pkg::WORD_W'(1) << bitpos;
  assign last_plane = (plane + ibpa_pkg::DEPTH_W'(1)) == job.planes;

  always_comb begin
    put_bit = 1'b0;
    if (32'(plane) < ibpa_pkg::COLOR_W) begin
      put_bit = job.color[plane[ibpa_pkg::CIDX_W-1:0]];
    end
    acc_next = acc;
    acc_next[plane[ibpa_pkg::CIDX_W-1:0]] = mem_rdata[bitpos];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = plane_addr;
    mem_wdata = put_bit ? (mem_rdata | mask) : (mem_rdata & ~mask);
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == ST_MODIFY && job.kind == ibpa_pkg::KIND_PUT) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[plane_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(FB_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            job   <= q_job;
            base  <= q_base;
            plane <= '0;
            acc   <= '0;
            if (q_job.outside || q_job.planes == '0) begin
              result_valid        <= (q_job.kind == ibpa_pkg::KIND_GET);
              result.read_color   <= '0;
              result.out_of_range <= q_job.outside;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state <= ST_MODIFY;
        end
        ST_MODIFY: begin
          acc   <= acc_next;
          plane <= plane + ibpa_pkg::DEPTH_W'(1);
          if (last_plane) begin
            state <= ST_IDLE;
            if (job.kind == ibpa_pkg::KIND_GET) begin
              result_valid        <= 1'b1;
              result.read_color   <= acc_next;
              result.out_of_range <= 1'b0;
            end
          end else begin
            state <= ST_READ;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### hdl/interleaved_bitplane_pixel_access_top.sv
// Pixel put/get engine over an interleaved bit-plane frame buffer.
// Channels: an item is taken at a rising edge with start high and busy low.
//   item.kind selects put (store pixel_color at x,y) or get (read back colour).
//   A get gives one result on result for exactly one cycle, flagged by
//   result_valid; a put gives none. The receiver cannot stall the block.
// Config: cfg_we/cfg_index/cfg_data write plane_depth (index 0) or
//   line_stride_words (index 1); write only while the block is idle.
// Flow: the accepting edge registers the address products, the next edge
//   sums them, bound-checks and queues the job, the back end takes it from
//   the queue once idle, then a read and a modify state per plane visited;
//   out-of-range items and depth zero skip the plane visits.
// Overlap: the word store's read-modify-write visits each plane in turn, and
//   the back end takes no new job until the last one is through. A two-entry
//   queue lets the front take further items meanwhile; busy rises when the
//   queued jobs plus the one in the front stage reach two.
// Reset: rst (synchronous) restores depth 4 and stride 80, then a clearing
//   pass zeroes the store one word per cycle, during which busy stays high.
//   Config writes are taken throughout.
module interleaved_bitplane_pixel_access_top #(
  parameter int FB_WORDS  = ibpa_pkg::FB_WORDS_DEF,
  parameter int MAX_DEPTH = ibpa_pkg::MAX_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  ibpa_pkg::in_item_t              item,
  output logic                            result_valid,
  output ibpa_pkg::out_item_t             result,
  input  logic                            cfg_we,
  input  logic [ibpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibpa_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(FB_WORDS);
  localparam int JOB_W  = $bits(ibpa_pkg::job_t);
  localparam int CNT_W  = $clog2(ibpa_pkg::QUEUE_DEPTH + 1);

  // front -> queue
  logic                push;
  logic [ADDR_W-1:0]   push_base;
  ibpa_pkg::job_t      push_job;

  // queue -> back
  logic [ADDR_W+JOB_W-1:0] q_data;
  logic                    q_valid;
  logic [CNT_W-1:0]        q_count;
  logic                    pop;
  logic                    clearing;

  ibpa_front #(
    .FB_WORDS  (FB_WORDS),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .q_count   (q_count),
    .busy      (busy),
    .push      (push),
    .push_base (push_base),
    .push_job  (push_job)
  );

  // job queue: word address in the upper bits, classified job below
  ibpa_queue #(
    .W (ADDR_W + JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wdata     ({push_base, push_job}),
    .pop       (pop),
    .rdata     (q_data),
    .not_empty (q_valid),
    .count     (q_count)
  );

  ibpa_back #(
    .FB_WORDS (FB_WORDS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_base       (q_data[ADDR_W+JOB_W-1:JOB_W]),
    .q_job        (ibpa_pkg::job_t'(q_data[JOB_W-1:0])),
    .pop          (pop),
    .clearing     (clearing),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

### hdl/ibpa_checker.sv
module ibpa_checker (
  input logic                clk,
  input logic                rst,
  input logic                busy,
  input logic                result_valid,
  input ibpa_pkg::out_item_t result
);

  // clearing pass follows every reset
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_quiet_after_rst: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result straight after reset");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_of_range) |-> (result.read_color == '0))
    else $error("out-of-range get returned a colour");

  // no result may appear while reset is held
  a_no_early_result: assert property (@(posedge clk)
    ($past(rst) && rst) |=> !result_valid)
    else $error("result while reset held");

endmodule

bind interleaved_bitplane_pixel_access_top ibpa_checker u_ibpa_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ibpa_pkg::*;

  // Pause after the last expected colour before touching a register or ending:
  // the front stage, the two-entry job queue and the job in flight at full
  // depth, plus margin.
  localparam int SETTLE_CYCLES = 120;
  localparam int N_PHASES      = 12;
  localparam int RAND_PER_PHASE = 120;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start;
  logic                  busy;
  in_item_t              item;
  logic                  result_valid;
  out_item_t             result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  interleaved_bitplane_pixel_access_top u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the block: its own copy of the plane store and of both registers.
  // The store starts all zero, as after the clearing pass.
  // ---------------------------------------------------------------------------
  bit [WORD_W-1:0] frame_model [FB_WORDS_DEF];
  int unsigned     model_depth  = DEPTH_RST;
  int unsigned     model_stride = STRIDE_RST;

  in_item_t  pending_items [$];   // items still to be offered
  out_item_t colour_expect_q [$]; // colours owed by accepted gets, oldest first
  int        mismatch_count = 0;
  int        idle_pct = 0;        // chance, in percent, that the sender pauses
  int        idle_left = 0;

  // Applies one accepted item to the shadow store; a get leaves its colour
  // in the expectation queue.
  function automatic void apply_pixel_item(input in_item_t it);
    int unsigned depth;
    int unsigned base;
    int unsigned bit_sel;
    int unsigned p;
    logic        outside;
    out_item_t   res;
    // depths past MAX_DEPTH saturate
    depth   = (model_depth > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : model_depth;
    base    = it.y * model_stride + (it.x >> 4) * depth;
    bit_sel = WORD_W - 1 - it.x[3:0];   // leftmost pixel sits in the MSB
    // any plane word at or past the end voids the whole access
    outside = (base + depth) > FB_WORDS_DEF;
    res     = '0;
    if (!outside) begin
      for (p = 0; p < depth; p++) begin
        if (it.kind == KIND_PUT) begin
          // planes above the colour width get zero
          frame_model[base + p][bit_sel] = (p < COLOR_W) ? it.pixel_color[p] : 1'b0;
        end else if (p < COLOR_W) begin
          res.read_color[p] = frame_model[base + p][bit_sel];
        end
      end
    end
    if (it.kind == KIND_GET) begin
      res.out_of_range = outside;
      colour_expect_q.push_back(res);
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at %0t ns: %s", $time, what);
  endfunction

  // Gap before the next item: none in burst phases; else, with chance idle_pct, a random pause.
  function automatic int draw_gap();
    if ($urandom_range(0, 99) < idle_pct) return $urandom_range(1, 19);
    return 0;
  endfunction

  function automatic void queue_item(input logic kind, input int unsigned x,
                                     input int unsigned y, input int unsigned colour);
    in_item_t it;
    it.kind        = kind;
    it.x           = x[COORD_BITS-1:0];
    it.y           = y[COORD_BITS-1:0];
    it.pixel_color = colour[COLOR_W-1:0];
    pending_items.push_back(it);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, holds each until the block takes it, and
  // predicts at the edge of acceptance. start gets at most one assignment per edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left = 0;
    end else if (!start || !busy) begin
      if (start) begin
        apply_pixel_item(item);
        idle_left = draw_gap();
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_items.size() != 0) begin
        item  <= pending_items.pop_front();
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result is matched against the oldest owed colour.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid) begin
      if (colour_expect_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: colour %02h out_of_range %0b",
                                result.read_color, result.out_of_range));
      end else begin
        want = colour_expect_q.pop_front();
        if (result.read_color !== want.read_color)
          note_mismatch($sformatf("read_color: expected %02h, got %02h",
                                  want.read_color, result.read_color));
        if (result.out_of_range !== want.out_of_range)
          note_mismatch($sformatf("out_of_range: expected %0b, got %0b",
                                  want.out_of_range, result.out_of_range));
      end
    end
  end

  // Register write; the shadow copy follows at once, nothing being in flight.
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_PLANE_DEPTH) model_depth = val[DEPTH_W-1:0];
    else model_stride = val[STRIDE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every item to be taken and every colour to come back, then let
  // trailing puts finish inside the block.
  task automatic drain();
    while (pending_items.size() != 0 || start) @(negedge clk);
    while (colour_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. Phase 0 runs on the reset settings and opens with a directed
  // sweep; each later phase reprograms both registers (depth zero, depth
  // saturation, stride zero, widest stride among them) and then mixes put and
  // get traffic on a small patch of pixels, so that gets read back what puts
  // left, with some items scattered over the whole coordinate space.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned depth_plan [N_PHASES];
    int unsigned stride_plan [N_PHASES];
    int unsigned eff_stride;
    int unsigned row_lim;
    int unsigned x_base;
    int unsigned y_base;
    int unsigned pick;
    int          ph;
    int          n;

    start     = 1'b0;
    item      = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_PLANE_DEPTH;
    cfg_data  = '0;

    depth_plan  = '{4, 1, 8, 0, 12, 3, 8, 15, 2, 0, 0, 0};
    stride_plan = '{80, 1, 4096, 80, 40, 0, 8191, 1, 4096, 0, 0, 0};
    for (ph = 9; ph < N_PHASES; ph++) begin
      depth_plan[ph]  = $urandom_range(0, 15);
      stride_plan[ph] = $urandom_range(0, 8191);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (ph = 0; ph < N_PHASES; ph++) begin
      if (ph != 0) begin
        drain();
        // spare upper data bits ride along on depth writes; only 4 bits count
        write_reg(REG_PLANE_DEPTH, {9'($urandom_range(0, 511)), 4'(depth_plan[ph])});
        write_reg(REG_LINE_STRIDE, 13'(stride_plan[ph]));
      end
      // burst phases, light idling and heavy idling in turn
      idle_pct = (ph % 3 == 1) ? 0 : ((ph % 3 == 0) ? 35 : 75);
      @(negedge clk);

      if (ph == 0) begin
        // depth 4, stride 80: store ends after row 819 word 15
        queue_item(KIND_GET, 0, 0, 0);            // fresh store reads zero
        queue_item(KIND_PUT, 0, 0, 8'hFF);
        queue_item(KIND_GET, 0, 0, 0);
        queue_item(KIND_PUT, 15, 0, 8'hA5);       // rightmost pixel of a group
        queue_item(KIND_GET, 15, 0, 0);
        queue_item(KIND_GET, 14, 0, 0);           // neighbour untouched
        queue_item(KIND_PUT, 4095, 0, 8'h0F);     // widest column
        queue_item(KIND_GET, 4095, 0, 0);
        queue_item(KIND_PUT, 1000, 100, 8'h3C);
        queue_item(KIND_PUT, 1000, 100, 8'hC3);   // overwrite clears old bits
        queue_item(KIND_GET, 1000, 100, 0);
        queue_item(KIND_PUT, 48, 819, 8'h5A);     // last in-range group
        queue_item(KIND_GET, 48, 819, 0);
        queue_item(KIND_PUT, 64, 819, 8'hFF);     // just past the store
        queue_item(KIND_GET, 64, 819, 0);
        queue_item(KIND_PUT, 4095, 818, 8'h81);   // runs off the end
        queue_item(KIND_GET, 4095, 818, 0);
        queue_item(KIND_GET, 4095, 4095, 0);      // both coordinates at maximum
        queue_item(KIND_GET, 0, 4095, 0);
      end

      // patch of 48 x 4 pixels, placed so that most of it lands in the store
      eff_stride = (model_stride == 0) ? 1 : model_stride;
      row_lim    = FB_WORDS_DEF / eff_stride;
      if (row_lim > 4092) row_lim = 4092;
      y_base = $urandom_range(0, (row_lim > 4) ? row_lim - 4 : 0);
      x_base = $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom_range(0, 4048);

      for (n = 0; n < RAND_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)
          queue_item(KIND_PUT, x_base + $urandom_range(0, 47), y_base + $urandom_range(0, 3),
                     $urandom);
        else if (pick < 80)
          queue_item(KIND_GET, x_base + $urandom_range(0, 47), y_base + $urandom_range(0, 3),
                     $urandom);
        else
          queue_item(1'($urandom), $urandom, $urandom, $urandom);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: a time limit several times the slowest correct run, including the
  // clearing pass after reset.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
